@@ design/ptbq_pkg.sv @@
package ptbq_pkg;
  localparam int NUM_VARS    = 1024;
  localparam int NUM_CLASSES = 64;
  localparam int NUM_OBJECTS = 64;
  localparam int VAR_W  = $clog2(NUM_VARS);
  localparam int CLS_W  = 6;
  localparam int OBJ_W  = 6;
  localparam int ROW_W  = 64;
  localparam int IDX_W  = 6;
  localparam int QDEPTH = 2;

  // The last code is unused as an input action; the engine reuses it internally
  // for the mirrored half of an alias pair load.
  typedef enum logic [3:0] {
    ACT_MAP       = 4'd0,
    ACT_LOAD_PTS  = 4'd1,
    ACT_LOAD_AL   = 4'd2,
    ACT_IS_ALIAS  = 4'd3,
    ACT_IS_PTS    = 4'd4,
    ACT_LIST_PTS  = 4'd5,
    ACT_LIST_PBY  = 4'd6,
    ACT_LIST_AL   = 4'd7,
    ACT_OR_PT     = 4'd8,
    ACT_AND_PT    = 4'd9,
    ACT_AL_MIRROR = 4'd15
  } action_t;

  typedef struct packed {
    logic [3:0]       action;
    logic [9:0]       var_a;
    logic [9:0]       var_b;
    logic [CLS_W-1:0] class_a;
    logic [CLS_W-1:0] class_b;
    logic [OBJ_W-1:0] object_id;
    logic             is_representative;
    logic             last_point;
  } in_item_t;

  typedef struct packed {
    logic       entry_valid;
    logic       answer;
    logic [9:0] list_item;
    logic       last_result;
  } out_item_t;
endpackage

@@ design/ptbq_if.sv @@
interface ptbq_in_if;
  import ptbq_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptbq_out_if;
  import ptbq_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/points_to_bitmap_query_engine.sv @@
// Channel | Dir | Handshake          | Payload
// in_*    | in  | in_valid/in_ready  | action, var_a, var_b, class_a, class_b, object_id, ...
// out_*   | out | out_valid/out_ready| entry_valid, answer, list_item, last_result
// Boolean queries, maps and loads pass through a map read, a row read and execute.
// Alias loads write both rows of the pair one after the other.
// List queries walk one row bit per cycle unless stalled; each representative adds an S_REP step.
// Reset is synchronous on rst_n; matrix rows are cleared through per-row valid bits.
// A two-entry queue lets the front accept items while the engine stalls on out_ready.
module points_to_bitmap_query_engine (
  input  logic clk,
  input  logic rst_n,
  ptbq_in_if.sink    in,
  ptbq_out_if.source out
);
  import ptbq_pkg::*;

  logic     q_valid, q_ready;
  in_item_t q_data;

  ptbq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in.valid),
    .wr_ready (in.ready),
    .wr_data  (in.data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  ptbq_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_data),
    .out       (out)
  );
endmodule

@@ design/ptbq_queue.sv @@
module ptbq_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  ptbq_pkg::in_item_t  wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output ptbq_pkg::in_item_t  rd_data
);
  import ptbq_pkg::*;

  in_item_t mem_r [QDEPTH];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'(QDEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QDEPTH))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !(rd_valid))
    else $error("read valid while empty");
  assert property (@(posedge clk) disable iff (!rst_n)
    (wr_valid && wr_ready && !(rd_valid && rd_ready)) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count mismatch");
endmodule

@@ design/ptbq_engine.sv @@
module ptbq_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  ptbq_pkg::in_item_t cmd,
  ptbq_out_if.source         out
);
  import ptbq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD1  = 7'b0000010,
    S_RD2  = 7'b0000100,
    S_EXEC = 7'b0001000,
    S_WALK = 7'b0010000,
    S_REP  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state_r;
  in_item_t cmd_r;

  logic [CLS_W-1:0] class_of_var [NUM_VARS];
  logic [9:0]       rep_of_class [NUM_CLASSES];
  logic [ROW_W-1:0] pts_mem [NUM_CLASSES];
  logic [ROW_W-1:0] pby_mem [NUM_OBJECTS];
  logic [ROW_W-1:0] al_mem  [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] pts_v_r, pby_v_r, al_v_r;

  logic [CLS_W-1:0] cva_r, cvb_r;
  logic [ROW_W-1:0] pts_a_q, pts_b_q, al_q, pby_q;
  logic [9:0]       rep_q;
  logic [ROW_W-1:0] row_r, acc_r;
  logic             group_r;
  logic [IDX_W-1:0] idx_r;
  logic             map_r;
  logic             ovalid_r;
  out_item_t        odata_r;

  assign cmd_ready = (state_r == S_IDLE);
  assign out.valid = ovalid_r;
  assign out.data  = odata_r;

  // Valid bits stand in for the reset-cleared matrix rows.
  logic [ROW_W-1:0] pts_a, pts_b, al_row, pby_row;
  assign pts_a   = pts_v_r[cva_r] ? pts_a_q : '0;
  assign pts_b   = pts_v_r[cvb_r] ? pts_b_q : '0;
  assign al_row  = al_v_r[cva_r]  ? al_q    : '0;
  assign pby_row = pby_v_r[cmd_r.object_id] ? pby_q : '0;

  logic out_free;
  assign out_free = !ovalid_r || out.ready;

  logic             bit_set, rest_empty;
  logic [ROW_W-1:0] above_mask;
  assign bit_set    = row_r[idx_r];
  assign above_mask = ~((ROW_W'(2) << idx_r) - ROW_W'(1));
  assign rest_empty = ((row_r & above_mask) == '0);

  logic [ROW_W-1:0] comb_row;
  always_comb begin
    if (!group_r)                          comb_row = al_row;
    else if (cmd_r.action == ACT_OR_PT)    comb_row = acc_r | al_row;
    else                                   comb_row = acc_r & al_row;
  end

  // Memory reads, addressed by the registered command or by the class read.
  // Loads address the rows directly by their class field.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && cmd_valid) begin
      if (cmd.action == ACT_LOAD_PTS || cmd.action == ACT_LOAD_AL) cva_r <= cmd.class_a;
      else cva_r <= class_of_var[cmd.var_a[VAR_W-1:0]];
      cvb_r <= class_of_var[cmd.var_b[VAR_W-1:0]];
    end else if (state_r == S_EXEC && out_free && cmd_r.action == ACT_LOAD_AL) begin
      cva_r <= cmd_r.class_b;
    end
    pts_a_q <= pts_mem[cva_r];
    pts_b_q <= pts_mem[cvb_r];
    al_q    <= al_mem[cva_r];
    pby_q   <= pby_mem[cmd_r.object_id];
    rep_q   <= rep_of_class[idx_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      case (cmd_r.action)
        ACT_MAP: begin
          class_of_var[cmd_r.var_a[VAR_W-1:0]] <= cmd_r.class_a;
          if (cmd_r.is_representative) rep_of_class[cmd_r.class_a] <= cmd_r.var_a;
        end
        ACT_LOAD_PTS: begin
          pts_mem[cmd_r.class_a]   <= pts_a | (ROW_W'(1) << cmd_r.object_id);
          pby_mem[cmd_r.object_id] <= pby_row | (ROW_W'(1) << cmd_r.class_a);
        end
        default: ;
      endcase
    end
    if (state_r == S_EXEC && cmd_r.action == ACT_LOAD_AL) begin
      al_mem[cmd_r.class_a] <= al_row | (ROW_W'(1) << cmd_r.class_b);
    end
    if (state_r == S_EMIT) begin
      al_mem[cmd_r.class_b] <= row_r | (ROW_W'(1) << cmd_r.class_a);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      pts_v_r  <= '0;
      pby_v_r  <= '0;
      al_v_r   <= '0;
      group_r  <= 1'b0;
      acc_r    <= '0;
      idx_r    <= '0;
      map_r    <= 1'b0;
    end else begin
      if (ovalid_r && out.ready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (cmd_valid) begin
          cmd_r   <= cmd;
          state_r <= S_RD1;
        end
        S_RD1: state_r <= S_RD2;
        S_RD2: state_r <= S_EXEC;
        S_EXEC: if (out_free) begin
          odata_r  <= '{entry_valid: 1'b0, answer: 1'b0, list_item: '0, last_result: 1'b1};
          idx_r    <= '0;
          map_r    <= 1'b0;
          state_r  <= S_IDLE;
          ovalid_r <= 1'b1;
          case (cmd_r.action)
            ACT_LOAD_PTS: begin
              pts_v_r[cmd_r.class_a]   <= 1'b1;
              pby_v_r[cmd_r.object_id] <= 1'b1;
            end
            ACT_LOAD_AL: begin
              // Second half of the pair is written in S_EMIT, after the read states and a mirror execute.
              al_v_r[cmd_r.class_a] <= 1'b1;
              ovalid_r <= 1'b0;
              map_r    <= 1'b1;
              state_r  <= S_RD1;
              cmd_r.action <= ACT_AL_MIRROR;
            end
            ACT_IS_ALIAS: odata_r.answer <= (cva_r == cvb_r) || ((pts_a & pts_b) != '0);
            ACT_IS_PTS:   odata_r.answer <= pts_a[cmd_r.object_id];
            ACT_LIST_PTS: begin row_r <= pts_a;   ovalid_r <= 1'b0; state_r <= S_WALK; end
            ACT_LIST_PBY: begin row_r <= pby_row; ovalid_r <= 1'b0; state_r <= S_WALK; end
            ACT_LIST_AL: begin
              row_r <= al_row; ovalid_r <= 1'b0; map_r <= 1'b0;
              state_r <= S_WALK; cmd_r.last_point <= 1'b1;
            end
            ACT_OR_PT, ACT_AND_PT: begin
              acc_r   <= comb_row;
              group_r <= !cmd_r.last_point;
              if (cmd_r.last_point) begin
                row_r <= comb_row; ovalid_r <= 1'b0; state_r <= S_WALK;
              end
            end
            ACT_AL_MIRROR: begin
              if (map_r) begin
                row_r    <= al_row;
                ovalid_r <= 1'b0;
                state_r  <= S_EMIT;
              end
            end
            default: ;
          endcase
        end
        S_EMIT: begin
          al_v_r[cmd_r.class_b] <= 1'b1;
          map_r    <= 1'b0;
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        S_WALK: if (out_free) begin
          if (bit_set) begin
            if (cmd_r.action == ACT_LIST_AL || cmd_r.action == ACT_OR_PT ||
                cmd_r.action == ACT_AND_PT) begin
              ovalid_r <= 1'b0;
              state_r  <= S_REP;
            end else begin
              odata_r  <= '{entry_valid: 1'b1, answer: 1'b0,
                            list_item: 10'(idx_r), last_result: rest_empty};
              ovalid_r <= 1'b1;
              if (rest_empty) state_r <= S_IDLE;
              else idx_r <= idx_r + 1'b1;
            end
          end else if (idx_r == IDX_W'(ROW_W-1)) begin
            odata_r  <= '{entry_valid: 1'b0, answer: 1'b0, list_item: '0, last_result: 1'b1};
            ovalid_r <= 1'b1;
            state_r  <= S_IDLE;
          end else begin
            ovalid_r <= ovalid_r && !out.ready;
            idx_r    <= idx_r + 1'b1;
          end
        end
        S_REP: if (out_free) begin
          odata_r  <= '{entry_valid: 1'b1, answer: 1'b0, list_item: rep_q,
                        last_result: rest_empty};
          ovalid_r <= 1'b1;
          if (rest_empty) state_r <= S_IDLE;
          else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_WALK;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && ovalid_r && !out.ready) |=> $stable(odata_r))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && odata_r.entry_valid == 1'b0) |-> odata_r.last_result)
    else $error("non-entry result without last flag");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !cmd_ready)
    else $error("ready while busy");
endmodule

@@ tb/tb_points_to_bitmap_query_engine.sv @@
import ptbq_pkg::*;

class alias_query_scoreboard;
  logic [5:0]  class_of_var [NUM_VARS];
  logic [9:0]  rep_of_class [NUM_CLASSES];
  logic [63:0] pts_row [NUM_CLASSES];
  logic [63:0] pby_row [NUM_OBJECTS];
  logic [63:0] alias_row [NUM_CLASSES];
  logic [63:0] group_acc;
  bit          group_open;
  out_item_t   pending [$];
  int          errors;

  function new();
    for (int i = 0; i < NUM_VARS; i++) class_of_var[i] = '0;
    for (int i = 0; i < 64; i++) begin
      rep_of_class[i] = '0;
      pts_row[i] = '0;
      pby_row[i] = '0;
      alias_row[i] = '0;
    end
    group_acc = '0;
    group_open = 0;
    errors = 0;
  endfunction

  function void push(logic ev, logic ans, logic [9:0] item, logic last);
    out_item_t r;
    r.entry_valid = ev;
    r.answer = ans;
    r.list_item = item;
    r.last_result = last;
    pending.insert(pending.size(), r);
  endfunction

  // Lists come out in ascending bit order; the final entry carries the last flag.
  function void list_row(logic [63:0] row, bit as_rep);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) begin
      if (row[i]) begin
        push(1'b1, 1'b0, as_rep ? rep_of_class[i] : 10'(i), 1'b0);
        n++;
      end
    end
    if (n == 0) push(1'b0, 1'b0, '0, 1'b1);
    else pending[$].last_result = 1'b1;
  endfunction

  function void note_item(in_item_t t);
    logic [5:0]  ca, cb;
    logic [63:0] row;
    ca = class_of_var[t.var_a];
    cb = class_of_var[t.var_b];
    case (t.action)
      ACT_MAP: begin
        class_of_var[t.var_a] = t.class_a;
        if (t.is_representative) rep_of_class[t.class_a] = t.var_a;
        push(0, 0, 0, 1);
      end
      ACT_LOAD_PTS: begin
        pts_row[t.class_a][t.object_id] = 1'b1;
        pby_row[t.object_id][t.class_a] = 1'b1;
        push(0, 0, 0, 1);
      end
      ACT_LOAD_AL: begin
        alias_row[t.class_a][t.class_b] = 1'b1;
        alias_row[t.class_b][t.class_a] = 1'b1;
        push(0, 0, 0, 1);
      end
      ACT_IS_ALIAS: push(0, (ca == cb) || ((pts_row[ca] & pts_row[cb]) != 0), 0, 1);
      ACT_IS_PTS:   push(0, pts_row[ca][t.object_id], 0, 1);
      ACT_LIST_PTS: list_row(pts_row[ca], 0);
      ACT_LIST_PBY: list_row(pby_row[t.object_id], 0);
      ACT_LIST_AL:  list_row(alias_row[ca], 1);
      ACT_OR_PT, ACT_AND_PT: begin
        row = alias_row[ca];
        if (!group_open) group_acc = row;
        else if (t.action == ACT_OR_PT) group_acc |= row;
        else group_acc &= row;
        group_open = 1;
        if (t.last_point) begin
          group_open = 0;
          list_row(group_acc, 1);
        end else begin
          push(0, 0, 0, 1);
        end
      end
      default: push(0, 0, 0, 1);
    endcase
  endfunction

  function void check_result(out_item_t got);
    out_item_t exp;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %p", $time, got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got.entry_valid !== exp.entry_valid)
      $display("%0t: entry_valid expected %0b actual %0b", $time, exp.entry_valid,
               got.entry_valid);
    if (got.answer !== exp.answer)
      $display("%0t: answer expected %0b actual %0b", $time, exp.answer, got.answer);
    if (got.list_item !== exp.list_item)
      $display("%0t: list_item expected %0d actual %0d", $time, exp.list_item,
               got.list_item);
    if (got.last_result !== exp.last_result)
      $display("%0t: last_result expected %0b actual %0b", $time, exp.last_result,
               got.last_result);
    if (got !== exp) errors++;
  endfunction
endclass

module tb_points_to_bitmap_query_engine;
  logic clk;
  logic rst_n;
  ptbq_in_if  in_ch ();
  ptbq_out_if out_ch ();

  points_to_bitmap_query_engine i_dut (
    .clk  (clk),
    .rst_n(rst_n),
    .in   (in_ch.sink),
    .out  (out_ch.source)
  );

  alias_query_scoreboard sb;
  bit   mapped [NUM_VARS];
  int   mapped_list [$];
  bit   rep_set [NUM_CLASSES];
  bit   hold_results;
  int   idle_cycles;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Valid stays high after an accepted transaction until the next one or an idle stretch.
  task automatic send_item(in_item_t t, bit gaps);
    int g;
    g = gaps ? short_or_long_gap() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(t);
    if (t.action == ACT_MAP) begin
      if (!mapped[t.var_a]) mapped_list.insert(mapped_list.size(), int'(t.var_a));
      mapped[t.var_a] = 1;
      if (t.is_representative) rep_set[t.class_a] = 1;
    end
  endtask

  function automatic in_item_t blank(action_t a);
    in_item_t t;
    t = '0;
    t.action = a;
    return t;
  endfunction

  function automatic logic [9:0] known_var();
    return 10'(mapped_list[$urandom_range(0, mapped_list.size() - 1)]);
  endfunction

  // Maps one variable; callers give every class a representative so alias lists never read an unset entry.
  task automatic map_var(int v, int c, bit rep, bit gaps);
    in_item_t t;
    t = blank(ACT_MAP);
    t.var_a = 10'(v);
    t.class_a = 6'(c);
    t.is_representative = rep;
    send_item(t, gaps);
  endtask

  function automatic in_item_t random_item();
    in_item_t t;
    int k;
    t = '0;
    k = $urandom_range(0, 99);
    t.var_a = known_var();
    t.var_b = known_var();
    t.class_a = 6'($urandom);
    t.class_b = 6'($urandom);
    t.object_id = 6'($urandom);
    t.last_point = ($urandom_range(0, 2) == 0);
    if (k < 8) begin
      t.action = ACT_MAP;
      t.var_a = 10'($urandom);
      t.is_representative = 1'($urandom);
      if (!rep_set[t.class_a]) t.is_representative = 1'b1;
    end
    else if (k < 22) t.action = ACT_LOAD_PTS;
    else if (k < 34) t.action = ACT_LOAD_AL;
    else if (k < 42) t.action = ACT_IS_ALIAS;
    else if (k < 50) t.action = ACT_IS_PTS;
    else if (k < 58) t.action = ACT_LIST_PTS;
    else if (k < 66) t.action = ACT_LIST_PBY;
    else if (k < 74) t.action = ACT_LIST_AL;
    else if (k < 86) t.action = ACT_OR_PT;
    else if (k < 97) t.action = ACT_AND_PT;
    else t.action = action_t'($urandom_range(10, 15));
    return t;
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_item_t t;
    sb = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    out_ch.ready <= 1'b0;
    hold_results = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every class gets a representative first.
    for (int c = 0; c < 64; c++) map_var(c == 63 ? 1023 : c * 16, c, 1, 0);
    map_var(1, 0, 0, 0);
    t = blank(ACT_LOAD_PTS); t.class_a = 63; t.object_id = 63; send_item(t, 0);
    t = blank(ACT_LOAD_PTS); t.class_a = 0;  t.object_id = 63; send_item(t, 0);
    t = blank(ACT_LOAD_AL);  t.class_a = 0;  t.class_b = 63;   send_item(t, 0);
    t = blank(ACT_LOAD_AL);  t.class_a = 5;  t.class_b = 5;    send_item(t, 0);
    t = blank(ACT_IS_ALIAS); t.var_a = 0; t.var_b = 1;         send_item(t, 0);
    t = blank(ACT_IS_ALIAS); t.var_a = 0; t.var_b = 1023;      send_item(t, 0);
    t = blank(ACT_IS_ALIAS); t.var_a = 16; t.var_b = 1023;     send_item(t, 0);
    t = blank(ACT_IS_PTS);   t.var_a = 1023; t.object_id = 63; send_item(t, 0);
    t = blank(ACT_IS_PTS);   t.var_a = 16; t.object_id = 0;    send_item(t, 0);
    t = blank(ACT_LIST_PTS); t.var_a = 1023;                   send_item(t, 0);
    t = blank(ACT_LIST_PTS); t.var_a = 32;                     send_item(t, 0);
    t = blank(ACT_LIST_PBY); t.object_id = 63;                 send_item(t, 0);
    t = blank(ACT_LIST_PBY); t.object_id = 1;                  send_item(t, 0);
    t = blank(ACT_LIST_AL);  t.var_a = 0;                      send_item(t, 0);
    t = blank(ACT_OR_PT);    t.var_a = 0;                      send_item(t, 0);
    t = blank(ACT_LIST_AL);  t.var_a = 80;                     send_item(t, 0);
    t = blank(ACT_AND_PT);   t.var_a = 1023; t.last_point = 1; send_item(t, 0);
    t = blank(ACT_AND_PT);   t.var_a = 80; t.last_point = 1;   send_item(t, 0);
    t = '1; t.action = action_t'(4'hF);                        send_item(t, 0);
    wait_drained();

    // Back-pressure: results held off while items keep coming.
    hold_results = 1;
    for (int i = 0; i < 12; i++) send_item(random_item(), 0);
    wait_drained();

    for (int i = 0; i < 200; i++) begin
      send_item(random_item(), 1);
      if (i == 100) wait_drained();
    end
    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** points_to_bitmap_query_engine: PASSED **");
    else
      $display("** points_to_bitmap_query_engine: FAILED **");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (hold_results) begin
        hold_results = 0;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      g = ($urandom_range(0, 3) == 0) ? short_or_long_gap() : 0;
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("** points_to_bitmap_query_engine: FAILED **");
      $finish;
    end
  end
endmodule
